// ----- rtl/core/tga_rle_pixel_decoder_defines.svh -----
// assertion macros for the checker file
`ifndef TGA_RLE_PIXEL_DECODER_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_DEFINES_SVH

// clocked property, switched off while reset is held
`define TRD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("trd assertion failed");

// clocked property that also holds during reset
`define TRD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("trd assertion failed");

`endif

// ----- rtl/core/trd_pkg.sv -----
`default_nettype none

package trd_pkg;

    localparam int TRD_BYTE_W     = 8;
    localparam int TRD_BPP_W      = 3;
    localparam int TRD_TOTAL_W    = 32;
    localparam int TRD_CFG_W      = 32;
    localparam int TRD_CFG_IDX_W  = 2;
    localparam int TRD_PIX_W      = 32;
    localparam int TRD_OUT_W      = 40;
    localparam int TRD_QUEUE_DEPTH = 2;

    // register indexes on the config port
    localparam logic [TRD_CFG_IDX_W-1:0] TRD_REG_BPP   = 2'd0;
    localparam logic [TRD_CFG_IDX_W-1:0] TRD_REG_RLE   = 2'd1;
    localparam logic [TRD_CFG_IDX_W-1:0] TRD_REG_TOTAL = 2'd2;

    // packet header fields
    localparam logic [6:0] TRD_HDR_COUNT_MASK = 7'h7f;
    localparam int         TRD_HDR_REPEAT_BIT = 7;

    // pixel size codes, bytes per pixel minus one
    localparam logic [1:0] TRD_SIZE_1 = 2'd0;
    localparam logic [1:0] TRD_SIZE_2 = 2'd1;
    localparam logic [1:0] TRD_SIZE_3 = 2'd2;
    localparam logic [1:0] TRD_SIZE_4 = 2'd3;

    // one decoded pixel on its way to the output stage
    typedef struct packed {
        logic [TRD_PIX_W-1:0] pixel;
        logic [1:0]           size_code;
        logic [7:0]           run;
        logic                 last;
    } pix_entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/trd_front.sv -----
`default_nettype none

module trd_front (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [trd_pkg::TRD_CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [trd_pkg::TRD_CFG_W-1:0]      cfg_wdata,
    input  wire logic                               in_fire,
    input  wire logic [trd_pkg::TRD_BYTE_W-1:0]     in_byte,
    output trd_pkg::pix_entry_t                     push_entry,
    output logic                                    push
);
    import trd_pkg::*;

    logic [TRD_BPP_W-1:0]   bpp_reg, bpp_next;
    logic                   rle_reg, rle_next;
    logic [TRD_TOTAL_W-1:0] total_reg, total_next;

    logic                   expect_hdr_reg, expect_hdr_next;
    logic                   repeat_reg, repeat_next;
    logic [7:0]             pkt_left_reg, pkt_left_next;
    logic [1:0]             byte_pos_reg, byte_pos_next;
    logic [TRD_PIX_W-1:0]   asm_reg, asm_next;
    logic [TRD_TOTAL_W-1:0] pix_left_reg, pix_left_next;

    logic [1:0]             size_code;
    logic [TRD_TOTAL_W-1:0] total_eff;
    logic [7:0]             run_raw;
    logic [7:0]             run;
    logic                   last;
    logic                   restart;

    // clamp pixel size into one to four bytes
    always_comb begin
        if (bpp_reg == '0) begin
            size_code = TRD_SIZE_1;
        end else if (bpp_reg > TRD_BPP_W'(4)) begin
            size_code = TRD_SIZE_4;
        end else begin
            size_code = 2'(bpp_reg - TRD_BPP_W'(1));
        end
    end

    assign total_eff = (total_next == '0) ? TRD_TOTAL_W'(1) : total_next;

    // repeat run, clipped to what the image still owes
    always_comb begin
        run_raw = (pkt_left_reg == 8'd0) ? 8'd1 : pkt_left_reg;
        if (rle_reg && repeat_reg) begin
            if (pix_left_reg[TRD_TOTAL_W-1:8] == '0 && run_raw > pix_left_reg[7:0]) begin
                run = pix_left_reg[7:0];
            end else begin
                run = run_raw;
            end
        end else begin
            run = 8'd1;
        end
    end

    assign last = (pix_left_reg == {{(TRD_TOTAL_W-8){1'b0}}, run});

    // decode state update
    always_comb begin
        bpp_next        = bpp_reg;
        rle_next        = rle_reg;
        total_next      = total_reg;
        expect_hdr_next = expect_hdr_reg;
        repeat_next     = repeat_reg;
        pkt_left_next   = pkt_left_reg;
        byte_pos_next   = byte_pos_reg;
        asm_next        = asm_reg;
        pix_left_next   = pix_left_reg;
        restart         = 1'b0;
        push            = 1'b0;

        if (cfg_we) begin
            case (cfg_index)
                TRD_REG_BPP: begin
                    bpp_next = cfg_wdata[TRD_BPP_W-1:0];
                    restart  = 1'b1;
                end
                TRD_REG_RLE: begin
                    rle_next = cfg_wdata[0];
                    restart  = 1'b1;
                end
                TRD_REG_TOTAL: begin
                    total_next = cfg_wdata[TRD_TOTAL_W-1:0];
                    restart    = 1'b1;
                end
                default: ;
            endcase
        end else if (in_fire) begin
            if (rle_reg && expect_hdr_reg) begin
                pkt_left_next   = {1'b0, in_byte[6:0] & TRD_HDR_COUNT_MASK} + 8'd1;
                repeat_next     = in_byte[TRD_HDR_REPEAT_BIT];
                expect_hdr_next = 1'b0;
                byte_pos_next   = 2'd0;
            end else begin
                asm_next[byte_pos_reg*TRD_BYTE_W +: TRD_BYTE_W] = in_byte;
                if (byte_pos_reg < size_code) begin
                    byte_pos_next = byte_pos_reg + 2'd1;
                end else begin
                    byte_pos_next = 2'd0;
                    push          = 1'b1;
                    if (rle_reg) begin
                        if (repeat_reg) begin
                            pkt_left_next = 8'd0;
                        end else if (pkt_left_reg != 8'd0) begin
                            pkt_left_next = pkt_left_reg - 8'd1;
                        end
                        if (pkt_left_next == 8'd0) begin
                            expect_hdr_next = 1'b1;
                        end
                    end
                    pix_left_next = pix_left_reg - {{(TRD_TOTAL_W-8){1'b0}}, run};
                    if (last) begin
                        restart = 1'b1;
                    end
                end
            end
        end

        if (restart) begin
            expect_hdr_next = 1'b1;
            repeat_next     = 1'b0;
            pkt_left_next   = 8'd0;
            byte_pos_next   = 2'd0;
            pix_left_next   = total_eff;
        end
    end

    // entry handed to the queue
    always_comb begin
        push_entry.pixel     = asm_next;
        push_entry.size_code = size_code;
        push_entry.run       = run;
        push_entry.last      = last;
    end

    // control and config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg        <= TRD_BPP_W'(1);
            rle_reg        <= 1'b0;
            total_reg      <= TRD_TOTAL_W'(1);
            expect_hdr_reg <= 1'b1;
            repeat_reg     <= 1'b0;
            pkt_left_reg   <= 8'd0;
            byte_pos_reg   <= 2'd0;
            pix_left_reg   <= TRD_TOTAL_W'(1);
        end else begin
            bpp_reg        <= bpp_next;
            rle_reg        <= rle_next;
            total_reg      <= total_next;
            expect_hdr_reg <= expect_hdr_next;
            repeat_reg     <= repeat_next;
            pkt_left_reg   <= pkt_left_next;
            byte_pos_reg   <= byte_pos_next;
            pix_left_reg   <= pix_left_next;
        end
    end

    // pixel bytes, no reset needed
    always_ff @(posedge aclk) begin
        asm_reg <= asm_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/trd_queue.sv -----
`default_nettype none

module trd_queue #(
    parameter int DEPTH = trd_pkg::TRD_QUEUE_DEPTH
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire trd_pkg::pix_entry_t push_entry,
    output logic              not_full,
    output logic              not_empty,
    input  wire logic         pop,
    output trd_pkg::pix_entry_t pop_entry
);
    import trd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    pix_entry_t    slots [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign not_full  = (count_reg != CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_entry = slots[rd_ptr_reg];

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/trd_back.sv -----
`default_nettype none

module trd_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           q_valid,
    input  wire trd_pkg::pix_entry_t            q_entry,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [trd_pkg::TRD_OUT_W-1:0]       m_tdata,
    output logic                                m_tlast
);
    import trd_pkg::*;

    logic                 valid_reg, valid_next;
    logic [TRD_OUT_W-1:0] data_reg;
    logic                 last_reg;
    logic [7:0]           b0, b1, b2, b3;
    logic [7:0]           c0, c1, c2, c3;

    assign b0 = q_entry.pixel[7:0];
    assign b1 = q_entry.pixel[15:8];
    assign b2 = q_entry.pixel[23:16];
    assign b3 = q_entry.pixel[31:24];

    // channel order: 24 and 32 bit pixels arrive as bgr
    always_comb begin
        c0 = b0;
        c1 = 8'd0;
        c2 = 8'd0;
        c3 = 8'd0;
        unique case (q_entry.size_code)
            TRD_SIZE_1: begin
                c0 = b0;
            end
            TRD_SIZE_2: begin
                c0 = b0;
                c1 = b1;
            end
            TRD_SIZE_3: begin
                c0 = b2;
                c1 = b1;
                c2 = b0;
            end
            TRD_SIZE_4: begin
                c0 = b2;
                c1 = b1;
                c2 = b0;
                c3 = b3;
            end
            default: ;
        endcase
    end

    // output register refills whenever it is empty or being taken
    assign q_pop = q_valid && (!valid_reg || m_tready);

    always_comb begin
        valid_next = valid_reg;
        if (q_pop) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            data_reg <= {q_entry.run, c3, c2, c1, c0};
            last_reg <= q_entry.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/tga_rle_pixel_decoder.sv -----
// tga run-length pixel decoder
// s_ channel: one beat per byte of image data, packet headers and pixel bytes
// mixed as in the file. m_ channel: one beat per decoded pixel (repeat packets
// give one beat carrying their run length), m_tlast on the beat that finishes
// the image's pixel count.
// config port: cfg_we/cfg_index/cfg_wdata write bytes_per_pixel (0), rle_enable
// (1) and pixel_total (2); any listed write restarts the image. Write only idle.
// throughput: one byte per cycle while the queue has room; the decode state in the
// front end updates on every accepted byte, so bytes can stream back to back.
// path: the beat for a pixel is written into the queue on the edge that takes its
// last byte, then moves to the output register once that register is empty or
// being taken.
// stall: a held m_tready fills the output register and then the queue; s_tready
// drops only once the queue is full, so the front keeps taking bytes meanwhile.
// reset: synchronous, active low; config returns to one byte per pixel, raw data,
// one pixel per image, and the queue and output register empty.
`default_nettype none

module tga_rle_pixel_decoder #(
    parameter int QUEUE_DEPTH = trd_pkg::TRD_QUEUE_DEPTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [trd_pkg::TRD_CFG_IDX_W-1:0] cfg_index,
    input  wire logic [trd_pkg::TRD_CFG_W-1:0]     cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata: [7:0] data_byte
    input  wire logic [trd_pkg::TRD_BYTE_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata: [7:0] chan0, [15:8] chan1, [23:16] chan2, [31:24] chan3,
    // [39:32] run_length
    output logic [trd_pkg::TRD_OUT_W-1:0]          m_tdata,
    // m_tlast: last_pixel
    output logic                                   m_tlast
);
    import trd_pkg::*;

    pix_entry_t push_entry;
    pix_entry_t pop_entry;
    logic       push;
    logic       pop;
    logic       q_not_full;
    logic       q_not_empty;
    logic       in_fire;

    assign s_tready = q_not_full;
    assign in_fire  = s_tvalid && s_tready;

    trd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_fire    (in_fire),
        .in_byte    (s_tdata),
        .push_entry (push_entry),
        .push       (push)
    );

    trd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .not_full   (q_not_full),
        .not_empty  (q_not_empty),
        .pop        (pop),
        .pop_entry  (pop_entry)
    );

    trd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_not_empty),
        .q_entry  (pop_entry),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/core/trd_checker.sv -----
`default_nettype none

`include "tga_rle_pixel_decoder_defines.svh"

module trd_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [trd_pkg::TRD_OUT_W-1:0] m_tdata
);
    import trd_pkg::*;

    // no beat is offered in the cycle after reset
    `TRD_ASSERT(a_idle_after_reset, aclk, aresetn, $past(!aresetn) |-> !m_tvalid)

    // a beat always covers at least one pixel
    `TRD_ASSERT(a_run_nonzero, aclk, aresetn, m_tvalid |-> (m_tdata[39:32] != 8'd0))

    // a run never exceeds one packet
    `TRD_ASSERT(a_run_max, aclk, aresetn, m_tvalid |-> (m_tdata[39:32] <= 8'd128))

    // a stalled beat holds its payload
    `TRD_ASSERT(a_hold_stall, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

endmodule

bind tga_rle_pixel_decoder trd_checker u_trd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
